### rtl/core/wtsg_pkg.sv
// Package for the waveform table sample generator.
// Holds the item and configuration types, register and mode codes, and the sine table function.
// No dependencies.
`default_nettype none

package wtsg_pkg;

   localparam int IDX_W       = 10;
   localparam int PHASE_W     = 16;
   localparam int DIV_STEPS   = IDX_W + PHASE_W;
   localparam int CODE_W      = 12;
   localparam int PP_W        = 13;
   localparam int DUTY_W      = 17;
   localparam int CSR_W       = 17;
   localparam int CSR_IDX_W   = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int ROM_W       = 15;

   localparam logic [1:0] MODE_SINE     = 2'd0;
   localparam logic [1:0] MODE_SQUARE   = 2'd1;
   localparam logic [1:0] MODE_TRIANGLE = 2'd2;
   localparam logic [1:0] MODE_FLAT     = 2'd3;

   localparam logic [CSR_IDX_W-1:0] REG_WAVE_MODE     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TABLE_LENGTH  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PEAK_TO_PEAK  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DC_OFFSET     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_DUTY_FRACTION = 3'd4;

   localparam logic [PP_W-1:0]   PP_MAX   = 13'd8190;
   localparam logic [DUTY_W-1:0] DUTY_MAX = 17'd65536;
   localparam logic [11:0]       PS_MAX   = 12'd4095;

   typedef struct packed {
      logic [IDX_W-1:0]   idx;
      logic [PHASE_W-1:0] phase;
   } item_type;

   typedef struct packed {
      logic [1:0]        mode;
      logic [PP_W-1:0]   pp;
      logic [CODE_W-1:0] dc;
      logic [10:0]       high;
   } cfg_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_status_type;

   function automatic logic [ROM_W-1:0] sine_q15(input int unsigned k, input int unsigned bits);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned prod;
      longint signed   sum;
      longint unsigned r;
      x = (64'd1686629713 * longint'(k)) >> bits;
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      for (int n = 1; n <= 8; n++) begin
         prod = (term * x2) >> 30;
         case (n)
            1: term = prod / 64'd6;
            2: term = prod / 64'd20;
            3: term = prod / 64'd42;
            4: term = prod / 64'd72;
            5: term = prod / 64'd110;
            6: term = prod / 64'd156;
            7: term = prod / 64'd210;
            default: term = prod / 64'd272;
         endcase
         if (n % 2 == 1) sum = sum - longint'(term);
         else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      r = (longint'(sum) + 64'd16384) >> 15;
      if (r > 64'd32767) r = 64'd32767;
      return ROM_W'(r);
   endfunction

endpackage

`default_nettype wire

### rtl/core/wtsg_front.sv
// Front end: pipelined restoring divider giving index mod length and the Q0.16 phase.
// Depends on wtsg_pkg.
`default_nettype none

module wtsg_front import wtsg_pkg::*; #(
   parameter int LEN_W = 11
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   input  wire logic [IDX_W-1:0] in_index,
   input  wire logic [LEN_W-1:0] len,
   input  wire logic             advance,
   output logic                  out_valid,
   output item_type              out_item
);

   logic               valid_ff [DIV_STEPS];
   logic [LEN_W-1:0]   rem_ff   [DIV_STEPS];
   logic [IDX_W-1:0]   num_ff   [DIV_STEPS];
   logic [IDX_W-1:0]   idx_ff   [DIV_STEPS];
   logic [PHASE_W-1:0] quo_ff   [DIV_STEPS];

   logic [LEN_W-1:0]   rem_in   [DIV_STEPS];
   logic [IDX_W-1:0]   num_in   [DIV_STEPS];
   logic [IDX_W-1:0]   idx_in   [DIV_STEPS];
   logic [PHASE_W-1:0] quo_in   [DIV_STEPS];
   logic [LEN_W:0]     cur_w    [DIV_STEPS];
   logic               ge_w     [DIV_STEPS];

   always_comb begin
      for (int s = 0; s < DIV_STEPS; s++) begin
         if (s == 0) begin
            cur_w[s] = {{LEN_W{1'b0}}, in_index[IDX_W-1]};
            num_in[s] = in_index << 1;
            quo_in[s] = '0;
            idx_in[s] = '0;
         end else begin
            cur_w[s] = {rem_ff[s-1], num_ff[s-1][IDX_W-1]};
            num_in[s] = num_ff[s-1] << 1;
            quo_in[s] = quo_ff[s-1];
            idx_in[s] = idx_ff[s-1];
         end
         ge_w[s] = cur_w[s] >= {1'b0, len};
         rem_in[s] = ge_w[s] ? LEN_W'(cur_w[s] - {1'b0, len}) : cur_w[s][LEN_W-1:0];
         quo_in[s] = {quo_in[s][PHASE_W-2:0], ge_w[s]};
         if (s == IDX_W - 1) idx_in[s] = IDX_W'(rem_in[s]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < DIV_STEPS; s++) valid_ff[s] <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= in_valid;
         for (int s = 1; s < DIV_STEPS; s++) valid_ff[s] <= valid_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int s = 0; s < DIV_STEPS; s++) begin
            rem_ff[s] <= rem_in[s];
            num_ff[s] <= num_in[s];
            idx_ff[s] <= idx_in[s];
            quo_ff[s] <= quo_in[s];
         end
      end
   end

   assign out_valid = valid_ff[DIV_STEPS-1];
   assign out_item  = '{idx: idx_ff[DIV_STEPS-1], phase: quo_ff[DIV_STEPS-1]};

endmodule

`default_nettype wire

### rtl/core/wtsg_queue.sv
// Short item queue between the divider front end and the waveform back end.
// Depends on wtsg_pkg.
`default_nettype none

module wtsg_queue import wtsg_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire item_type push_item,
   input  wire logic     pop,
   output item_type      head_item,
   output q_status_type  status
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type         entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop ? PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in = count_ff;
      if (push && !pop) count_in = CNT_W'(count_ff + 1'b1);
      else if (pop && !push) count_in = CNT_W'(count_ff - 1'b1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_item;
   end

   assign head_item    = entry_ff[rd_ptr_ff];
   assign status.empty = count_ff == '0;
   assign status.full  = count_ff == CNT_W'(QUEUE_DEPTH);

endmodule

`default_nettype wire

### rtl/core/wtsg_sine_rom.sv
// Quarter-wave Q0.15 sine table with registered read.
// Depends on wtsg_pkg for the table function.
`default_nettype none

module wtsg_sine_rom import wtsg_pkg::*; #(
   parameter int SINE_ROM_BITS = 10
) (
   input  wire logic                 clock,
   input  wire logic                 enable,
   input  wire logic [SINE_ROM_BITS:0] addr,
   output logic [ROM_W-1:0]          data
);

   localparam int DEPTH = (1 << SINE_ROM_BITS) + 1;

   logic [ROM_W-1:0] rom_w [DEPTH];
   logic [ROM_W-1:0] data_ff;

   for (genvar k = 0; k < DEPTH; k++) begin : g_rom
      localparam logic [ROM_W-1:0] ENTRY = sine_q15(k, SINE_ROM_BITS);
      assign rom_w[k] = ENTRY;
   end

   always_ff @(posedge clock) begin
      if (enable) data_ff <= rom_w[addr];
   end

   assign data = data_ff;

endmodule

`default_nettype wire

### rtl/core/wtsg_back.sv
// Back end: sine lookup, waveform scaling, clamping and the result register.
// Depends on wtsg_pkg and wtsg_sine_rom.
`default_nettype none

module wtsg_back import wtsg_pkg::*; #(
   parameter int SINE_ROM_BITS = 10
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire item_type     head_item,
   input  wire q_status_type q_status,
   output logic              pop,
   input  wire cfg_type      cfg,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output logic [CODE_W-1:0] rsp_dac_code
);

   localparam int A_W = SINE_ROM_BITS + 2;
   localparam logic [SINE_ROM_BITS:0] QUARTER = (SINE_ROM_BITS + 1)'(1) << SINE_ROM_BITS;

   logic                      adv;
   logic [A_W-1:0]            a_w;
   logic [SINE_ROM_BITS-1:0]  k_w;
   logic [SINE_ROM_BITS:0]    addr_w;
   logic [ROM_W-1:0]          rom_data;
   logic [PHASE_W+1:0]        p4_w;
   logic signed [18:0]        tri_in;

   logic                      b1_valid_ff;
   logic                      b1_neg_ff;
   logic [IDX_W-1:0]          b1_idx_ff;
   logic signed [18:0]        b1_tri_ff;

   logic [11:0]               ps_w;
   logic signed [16:0]        s_w;
   logic signed [31:0]        num_in;
   logic                      b2_valid_ff;
   logic signed [31:0]        b2_num_ff;

   logic [31:0]               shifted_w;
   logic [CODE_W-1:0]         code_in;
   logic                      out_valid_ff;
   logic [CODE_W-1:0]         code_ff;

   assign adv = !out_valid_ff || !rsp_stall;
   assign pop = adv && !q_status.empty;

   assign a_w    = head_item.phase[PHASE_W-1 -: A_W];
   assign k_w    = a_w[SINE_ROM_BITS-1:0];
   assign addr_w = a_w[SINE_ROM_BITS] ? QUARTER - {1'b0, k_w} : {1'b0, k_w};

   wtsg_sine_rom #(.SINE_ROM_BITS(SINE_ROM_BITS)) u_rom (
      .clock  (clock),
      .enable (adv),
      .addr   (addr_w),
      .data   (rom_data)
   );

   always_comb begin
      p4_w = {head_item.phase, 2'b00};
      if (head_item.phase < 16'd16384) tri_in = $signed({1'b0, p4_w});
      else if (head_item.phase < 16'd49152) tri_in = 19'sd131072 - $signed({1'b0, p4_w});
      else tri_in = 19'($signed({2'b00, p4_w}) - 20'sd262144);
   end

   always_comb begin
      ps_w = (cfg.pp > 13'(PS_MAX)) ? PS_MAX : cfg.pp[11:0];
      s_w = b1_neg_ff ? -$signed({2'b00, rom_data}) : $signed({2'b00, rom_data});
      unique case (cfg.mode)
         MODE_SINE: num_in = $signed(32'(cfg.dc) << 16) + $signed(32'(ps_w)) * 32'(s_w);
         MODE_SQUARE: begin
            if (12'(b1_idx_ff) < 12'(cfg.high))
               num_in = $signed(32'(cfg.dc) << 1) + $signed(32'(cfg.pp));
            else
               num_in = $signed(32'(cfg.dc) << 1) - $signed(32'(cfg.pp));
         end
         MODE_TRIANGLE: num_in = $signed(32'(cfg.dc) << 17)
                                 + $signed(32'(cfg.pp)) * 32'(b1_tri_ff);
         default: num_in = $signed(32'(cfg.dc));
      endcase
   end

   always_comb begin
      unique case (cfg.mode)
         MODE_SINE:     shifted_w = 32'(b2_num_ff) >> 16;
         MODE_SQUARE:   shifted_w = 32'(b2_num_ff) >> 1;
         MODE_TRIANGLE: shifted_w = 32'(b2_num_ff) >> 17;
         default:       shifted_w = 32'(b2_num_ff);
      endcase
      if (b2_num_ff < 0) code_in = '0;
      else if (shifted_w > 32'd4095) code_in = 12'd4095;
      else code_in = shifted_w[CODE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff <= 1'b0;
         b2_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         b1_valid_ff <= pop;
         b2_valid_ff <= b1_valid_ff;
         out_valid_ff <= b2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b1_neg_ff <= a_w[A_W-1];
         b1_idx_ff <= head_item.idx;
         b1_tri_ff <= tri_in;
         b2_num_ff <= num_in;
         code_ff <= code_in;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_dac_code = code_ff;

endmodule

`default_nettype wire

### rtl/core/waveform_table_sample_generator.sv
// Waveform table sample generator: maps a table index to the 12-bit DAC code of
// a sine, square, triangle or flat table entry. Depends on wtsg_pkg and all wtsg_ modules.
//
// Usage:
//   Input channel req_valid / req_stall / req_entry_index carries one table index per item.
//   Result channel rsp_valid / rsp_stall / rsp_dac_code returns one code per item, in order.
//   csr_write_enable / csr_index / csr_write_data writes wave_mode (0), table_length (1),
//   peak_to_peak (2), dc_offset (3) and duty_fraction (4); registers 1, 2 and 4 saturate
//   on write, other indexes are ignored. Write only while no item is in flight.
// Timing:
//   One item per clock sustained while rsp_stall is low. An item passes 26 divider steps
//   (10 for index mod length, 16 for the phase), the queue and three back-end
//   stages (sine lookup, scaling multiply, clamp into the result register).
// Reset:
//   Synchronous; empties the pipeline and queue and loads the register defaults.
// Stall:
//   A stalled result holds; the back end freezes, the queue fills, and once the queue
//   is full with an item waiting at the divider output, req_stall rises and the front
//   end holds.
`default_nettype none

module waveform_table_sample_generator import wtsg_pkg::*; #(
   parameter int MAX_TABLE     = 1024,
   parameter int SINE_ROM_BITS = 10
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [IDX_W-1:0]     req_entry_index,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [CODE_W-1:0]         rsp_dac_code,
   input  wire logic                 csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_write_data
);

   localparam int LEN_MAX = (MAX_TABLE < 2047) ? MAX_TABLE : 2047;
   localparam int LEN_W   = $clog2(LEN_MAX + 1);
   localparam int LEN_RST = (LEN_MAX < 1024) ? LEN_MAX : 1024;

   logic [1:0]        mode_ff;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [PP_W-1:0]   pp_ff, pp_in;
   logic [CODE_W-1:0] dc_ff;
   logic [DUTY_W-1:0] duty_ff, duty_in;
   logic [LEN_W-1:0]  high_ff;
   logic [LEN_W+DUTY_W-1:0] high_prod_w;

   logic         front_adv;
   logic         front_valid;
   item_type     front_item;
   logic         q_push;
   logic         q_pop;
   item_type     q_head;
   q_status_type q_status;
   cfg_type      cfg;

   always_comb begin
      if (csr_write_data[10:0] == 11'd0) len_in = LEN_W'(1);
      else if (32'(csr_write_data[10:0]) > LEN_MAX) len_in = LEN_W'(LEN_MAX);
      else len_in = LEN_W'(csr_write_data[10:0]);
      pp_in = (csr_write_data[PP_W-1:0] > PP_MAX) ? PP_MAX : csr_write_data[PP_W-1:0];
      duty_in = (csr_write_data > DUTY_MAX) ? DUTY_MAX : csr_write_data;
      high_prod_w = (LEN_W + DUTY_W)'(len_ff) * (LEN_W + DUTY_W)'(duty_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_SINE;
         len_ff <= LEN_W'(LEN_RST);
         pp_ff <= '0;
         dc_ff <= 12'd2048;
         duty_ff <= 17'd32768;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_WAVE_MODE:     mode_ff <= csr_write_data[1:0];
            REG_TABLE_LENGTH:  len_ff <= len_in;
            REG_PEAK_TO_PEAK:  pp_ff <= pp_in;
            REG_DC_OFFSET:     dc_ff <= csr_write_data[CODE_W-1:0];
            REG_DUTY_FRACTION: duty_ff <= duty_in;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      high_ff <= high_prod_w[LEN_W+15:16];
   end

   assign cfg = '{mode: mode_ff, pp: pp_ff, dc: dc_ff, high: 11'(high_ff)};

   assign front_adv = !front_valid || !q_status.full;
   assign req_stall = !front_adv;
   assign q_push    = front_valid && front_adv;

   wtsg_front #(.LEN_W(LEN_W)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_index  (req_entry_index),
      .len       (len_ff),
      .advance   (front_adv),
      .out_valid (front_valid),
      .out_item  (front_item)
   );

   wtsg_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (front_item),
      .pop       (q_pop),
      .head_item (q_head),
      .status    (q_status)
   );

   wtsg_back #(.SINE_ROM_BITS(SINE_ROM_BITS)) u_back (
      .clock        (clock),
      .reset        (reset),
      .head_item    (q_head),
      .q_status     (q_status),
      .pop          (q_pop),
      .cfg          (cfg),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_dac_code (rsp_dac_code)
   );

`ifndef ASSERT_OFF
   a_stall_on_full: assert property (@(posedge clock) disable iff (reset)
      front_valid && q_status.full |-> req_stall)
      else $error("front end not held while queue full");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_status.full)
      else $error("push into full queue");
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !front_valid)
      else $error("pipeline not cleared by reset");
`endif

endmodule

`default_nettype wire
